### rtl/core/retro_scanline_color_shift_filter_defines.svh
// Assertion macros shared by the scanline color shift filter RTL.
`ifndef RETRO_SCANLINE_COLOR_SHIFT_FILTER_DEFINES_SVH
`define RETRO_SCANLINE_COLOR_SHIFT_FILTER_DEFINES_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define RSCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rscf: same-cycle check failed");

// Next-cycle implication, checked on clk, idle during reset.
`define RSCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rscf: next-cycle check failed");

`endif

### rtl/core/rscf_pkg.sv
// Shared constants and types of the scanline color shift filter.
package rscf_pkg;

  // Horizontal color offset in pixels.
  localparam int SHIFT_PIXELS = 2;
  localparam int HIST_DEPTH   = 2 * SHIFT_PIXELS;
  localparam int WIN_SIZE     = HIST_DEPTH + 1;
  localparam int CNT_W        = $clog2(HIST_DEPTH + 1);
  localparam int D_W          = $clog2(SHIFT_PIXELS + 1);
  localparam int WIN_IDX_W    = $clog2(WIN_SIZE);

  // Gray conversion, Q14 weights.
  localparam int PROD_W = 22;
  localparam logic [13:0] COEF_R = 14'd4899;
  localparam logic [13:0] COEF_G = 14'd9617;
  localparam logic [13:0] COEF_B = 14'd1868;
  localparam logic [13:0] GRAY_ROUND = 14'd8192;
  localparam int GRAY_LSB = 14;

  // Scanline gain, Q0.16.
  localparam int GAIN_W = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd58982;
  localparam int SCALE_W = 8 + GAIN_W;
  localparam logic [SCALE_W-1:0] SCALE_ROUND = 24'd32768;

  // Register file.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_GAIN = 1'b0;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One queued job: the gray window ending at the current column.
  typedef struct packed {
    logic [WIN_SIZE-1:0][7:0] win;   // win[k] = gray k columns back
    logic [CNT_W-1:0]         col;   // current column, saturated
    logic                     line_end;
    logic                     odd_row;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/rscf_front.sv
// Front end: takes input beats, converts to gray, tracks line state, queues jobs.
module rscf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  input  logic                  frame_start,
  input  logic                  line_end,
  input  rscf_pkg::q_stat_t     q_stat,
  output logic                  q_push,
  output rscf_pkg::job_t        q_job
);

  // Product stage
  logic                          a_valid;
  logic [rscf_pkg::PROD_W-1:0]   a_pr;
  logic [rscf_pkg::PROD_W-1:0]   a_pg;
  logic [rscf_pkg::PROD_W-1:0]   a_pb;
  logic                          a_fs;
  logic                          a_le;

  // Line state
  logic [rscf_pkg::HIST_DEPTH-1:0][7:0] hist;
  logic [rscf_pkg::CNT_W-1:0]           col;
  logic                                 odd_row;

  logic [rscf_pkg::PROD_W-1:0] gray_sum;
  logic [7:0]                  gray;
  logic [rscf_pkg::CNT_W-1:0]  col_eff;
  logic                        odd_eff;
  logic                        need_push;
  logic                        advance;

  assign in_ready = !a_valid || advance;

  // Weighted products, one multiplier per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_pr <= rscf_pkg::PROD_W'(red_in)   * rscf_pkg::PROD_W'(rscf_pkg::COEF_R);
      a_pg <= rscf_pkg::PROD_W'(green_in) * rscf_pkg::PROD_W'(rscf_pkg::COEF_G);
      a_pb <= rscf_pkg::PROD_W'(blue_in)  * rscf_pkg::PROD_W'(rscf_pkg::COEF_B);
      a_fs <= frame_start;
      a_le <= line_end;
    end
  end

  // Gray sum, classification and job build
  always_comb begin
    gray_sum  = a_pr + a_pg + a_pb + rscf_pkg::PROD_W'(rscf_pkg::GRAY_ROUND);
    gray      = gray_sum[rscf_pkg::GRAY_LSB +: 8];
    col_eff   = a_fs ? '0 : col;
    odd_eff   = a_fs ? 1'b0 : odd_row;
    need_push = a_le || (col_eff >= rscf_pkg::CNT_W'(rscf_pkg::SHIFT_PIXELS));
    advance   = a_valid && (!need_push || !q_stat.full);
    q_push    = advance && need_push;
    q_job.win[0] = gray;
    for (int k = 1; k < rscf_pkg::WIN_SIZE; k++) begin
      q_job.win[k] = hist[k-1];
    end
    q_job.col      = col_eff;
    q_job.line_end = a_le;
    q_job.odd_row  = odd_eff;
  end

  // History shift, column count and row parity
  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= '0;
      col     <= '0;
      odd_row <= 1'b0;
    end else if (advance) begin
      if (a_le) begin
        hist    <= '0;
        col     <= '0;
        odd_row <= !odd_eff;
      end else begin
        hist[0] <= gray;
        for (int k = 1; k < rscf_pkg::HIST_DEPTH; k++) begin
          hist[k] <= hist[k-1];
        end
        col     <= (col_eff < rscf_pkg::CNT_W'(rscf_pkg::HIST_DEPTH)) ?
                   col_eff + 1'b1 : col_eff;
        odd_row <= odd_eff;
      end
    end
  end

endmodule

### rtl/core/rscf_queue.sv
// Short job queue between front end and back end.
module rscf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rscf_pkg::job_t      push_job,
  input  logic                pop,
  output rscf_pkg::job_t      pop_job,
  output rscf_pkg::q_stat_t   stat
);

  rscf_pkg::job_t                mem [rscf_pkg::QUEUE_DEPTH];
  logic [rscf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rscf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rscf_pkg::QPTR_W:0]     count;

  assign pop_job    = mem[rd_ptr];
  assign stat.full  = (count == (rscf_pkg::QPTR_W+1)'(rscf_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/rscf_back.sv
// Back end: expands queued jobs into output beats and applies the scanline gain on even rows.
module rscf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rscf_pkg::GAIN_W-1:0] gain,
  input  rscf_pkg::q_stat_t           q_stat,
  input  rscf_pkg::job_t              q_job,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  red_out,
  output logic [7:0]                  green_out,
  output logic [7:0]                  blue_out,
  output logic                        last_of_line
);

  // Current job and column offset d (output column = col - d)
  rscf_pkg::job_t             job;
  logic                       job_valid;
  logic [rscf_pkg::D_W-1:0]   d;

  // Product stage
  logic                         p_valid;
  logic [rscf_pkg::SCALE_W-1:0] p_r;
  logic [rscf_pkg::SCALE_W-1:0] p_g;
  logic [rscf_pkg::SCALE_W-1:0] p_b;
  logic [7:0]                   p_raw_r;
  logic [7:0]                   p_raw_g;
  logic [7:0]                   p_raw_b;
  logic                         p_last;
  logic                         p_odd;

  logic [rscf_pkg::WIN_IDX_W-1:0] d_idx;
  logic [rscf_pkg::WIN_IDX_W-1:0] s_idx;
  logic                           red_ok;
  logic                           blue_ok;
  logic [7:0]                     raw_r;
  logic [7:0]                     raw_g;
  logic [7:0]                     raw_b;
  logic                           done;
  logic                           step;
  logic                           work_free;
  logic                           o_free;
  logic                           p_free;
  logic [rscf_pkg::D_W-1:0]       d_start;
  logic [rscf_pkg::SCALE_W-1:0]   sum_r;
  logic [rscf_pkg::SCALE_W-1:0]   sum_g;
  logic [rscf_pkg::SCALE_W-1:0]   sum_b;

  assign o_free = !out_valid || out_ready;
  assign p_free = !p_valid || o_free;

  // Channel selection from the window
  always_comb begin
    d_idx   = rscf_pkg::WIN_IDX_W'(d);
    s_idx   = rscf_pkg::WIN_IDX_W'(rscf_pkg::SHIFT_PIXELS);
    red_ok  = (d >= rscf_pkg::D_W'(rscf_pkg::SHIFT_PIXELS));
    blue_ok = ({1'b0, job.col} >= ((rscf_pkg::CNT_W+1)'(d) +
                                   (rscf_pkg::CNT_W+1)'(rscf_pkg::SHIFT_PIXELS)));
    raw_g   = job.win[d_idx];
    raw_r   = red_ok  ? job.win[d_idx - s_idx] : 8'd0;
    raw_b   = blue_ok ? job.win[d_idx + s_idx] : 8'd0;
    done    = !job.line_end || (d == '0);
    step    = job_valid && p_free;
    work_free = !job_valid || (step && done);
    q_pop   = !q_stat.empty && work_free;
    // Line end walks d from min(col, shift) down to 0, ending at the current column
    if (q_job.line_end &&
        (q_job.col < rscf_pkg::CNT_W'(rscf_pkg::SHIFT_PIXELS))) begin
      d_start = q_job.col[rscf_pkg::D_W-1:0];
    end else begin
      d_start = rscf_pkg::D_W'(rscf_pkg::SHIFT_PIXELS);
    end
  end

  // Job register and column walk
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (work_free) begin
      job_valid <= q_pop;
    end
    if (q_pop) begin
      job <= q_job;
      d   <= d_start;
    end else if (step && !done) begin
      d <= d - 1'b1;
    end
  end

  // Gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= step;
    end
    if (step) begin
      p_r     <= rscf_pkg::SCALE_W'(raw_r) * rscf_pkg::SCALE_W'(gain);
      p_g     <= rscf_pkg::SCALE_W'(raw_g) * rscf_pkg::SCALE_W'(gain);
      p_b     <= rscf_pkg::SCALE_W'(raw_b) * rscf_pkg::SCALE_W'(gain);
      p_raw_r <= raw_r;
      p_raw_g <= raw_g;
      p_raw_b <= raw_b;
      p_last  <= job.line_end && (d == '0);
      p_odd   <= job.odd_row;
    end
  end

  // Round half up, keep the integer byte
  always_comb begin
    sum_r = p_r + rscf_pkg::SCALE_ROUND;
    sum_g = p_g + rscf_pkg::SCALE_ROUND;
    sum_b = p_b + rscf_pkg::SCALE_ROUND;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= p_valid;
    end
    if (o_free && p_valid) begin
      red_out      <= p_odd ? p_raw_r : sum_r[rscf_pkg::GAIN_W +: 8];
      green_out    <= p_odd ? p_raw_g : sum_g[rscf_pkg::GAIN_W +: 8];
      blue_out     <= p_odd ? p_raw_b : sum_b[rscf_pkg::GAIN_W +: 8];
      last_of_line <= p_last;
    end
  end

endmodule

### rtl/core/retro_scanline_color_shift_filter.sv
// Retro scanline color shift filter: top level with register port and assertions.
// Path: front products, 4-entry job queue, job register, gain products, output register.
// Throughput: one pixel per cycle while the queue has room; the back end sends one beat
// per cycle while out_ready allows; the queue takes up line ends of up to SHIFT_PIXELS+1 beats.
// Reset (synchronous, rst high): the job queue, valids and line state clear, row parity even,
// scanline_gain returns to 58982.
`include "retro_scanline_color_shift_filter_defines.svh"

module retro_scanline_color_shift_filter (
  input  logic                        clk,
  input  logic                        rst,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rscf_pkg::ADDR_W-1:0] paddr,
  input  logic [rscf_pkg::DATA_W-1:0] pwdata,
  output logic [rscf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  red_in,
  input  logic [7:0]                  green_in,
  input  logic [7:0]                  blue_in,
  input  logic                        frame_start,
  input  logic                        line_end,
  // pixel output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  red_out,
  output logic [7:0]                  green_out,
  output logic [7:0]                  blue_out,
  output logic                        last_of_line
);

  logic [rscf_pkg::GAIN_W-1:0] scanline_gain;
  logic                        reg_sel;
  logic                        q_push;
  logic                        q_pop;
  rscf_pkg::job_t              push_job;
  rscf_pkg::job_t              pop_job;
  rscf_pkg::q_stat_t           q_stat;

  // Register decode
  assign pready  = 1'b1;
  assign reg_sel = (paddr[rscf_pkg::ADDR_W-1:2] == rscf_pkg::REG_GAIN);
  assign prdata  = reg_sel ? rscf_pkg::DATA_W'(scanline_gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scanline_gain <= rscf_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      scanline_gain <= pwdata[rscf_pkg::GAIN_W-1:0];
    end
  end

  rscf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .frame_start (frame_start),
    .line_end    (line_end),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  rscf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  rscf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gain         (scanline_gain),
    .q_stat       (q_stat),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_of_line (last_of_line)
  );

  // Queue checks
  `RSCF_ASSERT_NOW(a_push_not_full, q_push, !q_stat.full)
  `RSCF_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty)
  `RSCF_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full)

endmodule
